// ===== rtl/kcmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard code key map tracker package
// Shared payload types, command format and byte constants.
// ----------------------------------------------------------------------------
package kcmt_pkg;

    localparam logic OP_RX    = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [7:0] BYTE_PRESS       = 8'hA0;
    localparam logic [7:0] BYTE_RELEASE     = 8'hB0;
    localparam logic [7:0] BYTE_EXT_PRESS   = 8'hF2;
    localparam logic [7:0] BYTE_EXT_RELEASE = 8'hF1;
    localparam logic [7:0] BYTE_SKIP_A      = 8'hF0;
    localparam logic [7:0] BYTE_SKIP_B      = 8'hFA;
    localparam logic [7:0] CODE_CTRL        = 8'h7E;
    localparam logic [7:0] CODE_CLEAR_ALL   = 8'h7F;
    localparam logic [7:0] CTRL_OFFSET      = 8'h80;
    localparam logic [7:0] EXT_OFFSET       = 8'h2D;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_ALL     = 2'd3
    } t_key_ev;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic [4:0] query_index;
    } t_in;

    typedef struct packed {
        logic [1:0] key_event;
        logic [7:0] key_code;
        logic [7:0] map_byte;
    } t_out;

    typedef struct packed {
        t_key_ev    event_kind;
        logic [7:0] code;
        logic [4:0] query_index;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/keyboard_code_key_map_tracker_core.sv =====
// ----------------------------------------------------------------------------
// Keyboard code key map tracker
// Tracks a 256-bit pressed-key map from a stream of received keyboard bytes.
//
// The input channel carries one item per received byte or per map query;
// every item gives exactly one result on the output channel, in order.
// The result holds the key event caused by the item, the key code that
// changed and the selected map byte as it stands after the item.
// An accepted item is queued and then registered in the output register;
// the block takes one item per cycle when the output is not stalled.
// The parser keeps the prefix and control mode state and accepts an item
// whenever the two-entry command queue has room. The map update side
// drains the queue into the output register, so a stall on the output
// fills the queue and then raises o_stall after at most two more items.
// Reset is synchronous and active low: it clears the map, the parser
// state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module keyboard_code_key_map_tracker_core import kcmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic    push;
    logic    pop;
    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    t_q_stat q_stat;

    kcmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_stat (q_stat),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    kcmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_cmd   (queue_cmd)
    );

    kcmt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_cmd    (queue_cmd),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

    a_no_code_without_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.key_event == EV_NONE || o_data.key_event == EV_ALL)
            |-> o_data.key_code == 8'h00)
        else $error("key code set without a key event");

    a_clear_all_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.key_event == EV_ALL |-> o_data.map_byte == 8'h00)
        else $error("map byte not clear after all keys released");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> !q_stat.empty && o_valid)
        else $error("input stalled while the back end could drain");

endmodule

// ===== rtl/kcmt_front.sv =====
// ----------------------------------------------------------------------------
// Keyboard code key map tracker front end
// Parses prefix/code byte pairs and turns every item into one map command.
// ----------------------------------------------------------------------------
module kcmt_front import kcmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_in     i_data,
    input  t_q_stat i_q_stat,
    output logic    o_stall,
    output logic    o_push,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        PFX_IDLE        = 3'd0,
        PFX_PRESS       = 3'd1,
        PFX_RELEASE     = 3'd2,
        PFX_EXT_PRESS   = 3'd3,
        PFX_EXT_RELEASE = 3'd4,
        PFX_DROP        = 3'd5
    } t_pfx;

    t_pfx       r_pfx, n_pfx;
    logic       r_ctrl, n_ctrl;
    logic       r_arm, n_arm;
    t_key_ev    ev;
    logic [7:0] code;
    logic [7:0] off;
    logic [7:0] b;

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;
    assign b       = i_data.rx_byte;
    assign off     = r_ctrl ? CTRL_OFFSET : 8'h00;

    always_comb begin
        n_pfx  = r_pfx;
        n_ctrl = r_ctrl;
        n_arm  = r_arm;
        ev     = EV_NONE;
        code   = 8'h00;
        if (i_data.operation == OP_RX) begin
            unique case (r_pfx)
                PFX_IDLE: begin
                    priority if (b == BYTE_PRESS) begin
                        n_pfx = PFX_PRESS;
                    end else if (b == BYTE_RELEASE) begin
                        n_pfx = PFX_RELEASE;
                    end else if (b == BYTE_EXT_PRESS) begin
                        n_pfx = PFX_EXT_PRESS;
                    end else if (b == BYTE_EXT_RELEASE) begin
                        n_pfx = PFX_EXT_RELEASE;
                    end else if (b == BYTE_SKIP_A || b == BYTE_SKIP_B) begin
                        n_pfx = PFX_DROP;
                    end else begin
                        n_pfx = PFX_IDLE;
                    end
                end
                PFX_PRESS: begin
                    if (b < CODE_CTRL) begin
                        code = b + off;
                        ev   = EV_PRESS;
                    end else if (b == CODE_CTRL) begin
                        n_ctrl = 1'b1;
                    end
                    n_pfx = PFX_IDLE;
                end
                PFX_RELEASE: begin
                    priority if (b < CODE_CTRL) begin
                        code = b + off;
                        ev   = EV_RELEASE;
                        if (r_arm) begin
                            n_arm  = 1'b0;
                            n_ctrl = 1'b0;
                        end
                    end else if (b == CODE_CTRL) begin
                        n_arm = 1'b1;
                    end else if (b == CODE_CLEAR_ALL) begin
                        ev = EV_ALL;
                    end else begin
                        ev = EV_NONE;
                    end
                    n_pfx = PFX_IDLE;
                end
                PFX_EXT_PRESS: begin
                    code  = b + EXT_OFFSET;
                    ev    = EV_PRESS;
                    n_pfx = PFX_IDLE;
                end
                PFX_EXT_RELEASE: begin
                    code  = b + EXT_OFFSET;
                    ev    = EV_RELEASE;
                    n_pfx = PFX_IDLE;
                end
                default: begin
                    n_pfx = PFX_IDLE;
                end
            endcase
        end
    end

    assign o_cmd = '{event_kind: ev, code: code, query_index: i_data.query_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx  <= PFX_IDLE;
            r_ctrl <= 1'b0;
            r_arm  <= 1'b0;
        end else if (o_push) begin
            r_pfx  <= n_pfx;
            r_ctrl <= n_ctrl;
            r_arm  <= n_arm;
        end
    end

endmodule

// ===== rtl/kcmt_queue.sv =====
// ----------------------------------------------------------------------------
// Keyboard code key map tracker command queue
// Two-entry queue that decouples the parser from the map update.
// ----------------------------------------------------------------------------
module kcmt_queue import kcmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_cmd    o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_cmd        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/kcmt_back.sv =====
// ----------------------------------------------------------------------------
// Keyboard code key map tracker back end
// Applies map commands to the key map and registers one result per item.
// ----------------------------------------------------------------------------
module kcmt_back import kcmt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_cmd    i_cmd,
    input  logic    i_stall,
    output logic    o_pop,
    output logic    o_valid,
    output t_out    o_data
);

    logic [7:0] r_map [32];
    logic       r_valid;
    t_out       r_out;
    logic [4:0] row;
    logic [2:0] bit_sel;
    logic [7:0] n_row;
    logic [7:0] n_map_byte;
    logic       is_write;

    assign o_pop    = !i_q_stat.empty && (!r_valid || !i_stall);
    assign row      = i_cmd.code[7:3];
    assign bit_sel  = i_cmd.code[2:0];
    assign is_write = (i_cmd.event_kind == EV_PRESS) || (i_cmd.event_kind == EV_RELEASE);

    always_comb begin
        n_row          = r_map[row];
        n_row[bit_sel] = (i_cmd.event_kind == EV_PRESS);
    end

    always_comb begin
        if (i_cmd.event_kind == EV_ALL) begin
            n_map_byte = 8'h00;
        end else if (is_write && (row == i_cmd.query_index)) begin
            n_map_byte = n_row;
        end else begin
            n_map_byte = r_map[i_cmd.query_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_map[i] <= 8'h00;
            end
        end else if (o_pop) begin
            if (i_cmd.event_kind == EV_ALL) begin
                for (int i = 0; i < 32; i++) begin
                    r_map[i] <= 8'h00;
                end
            end else if (is_write) begin
                r_map[row] <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.key_event <= i_cmd.event_kind;
            r_out.key_code  <= i_cmd.code;
            r_out.map_byte  <= n_map_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule
